@@ hw/rtl/lctsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lctsm_pkg
// Shared types, constants and the control program of the tare, scale and
// median block.
// ----------------------------------------------------------------------------
package lctsm_pkg;

    localparam int WINDOW_DEF = 5;

    localparam int CODE_W  = 24;
    localparam int DIV_W   = 16;
    localparam int FRAC_W  = 12;   // dividend shift: 8 result fraction + 4 divisor fraction
    localparam int STEP_W  = 3;
    localparam int DCNT_W  = 5;
    localparam logic [DCNT_W-1:0] DIV_STEPS_M1 = DCNT_W'(CODE_W - 1);

    localparam logic [DIV_W-1:0] SCALE_RESET = 16'd6880;

    // configuration register indexes
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] REG_TARE  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SCALE = 2'd1;

    // datapath operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_PREP  = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;
    localparam logic [2:0] OP_RANK  = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;
    localparam logic [2:0] OP_BELOW = 3'd7;

    // jump conditions
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_JUMP     = 3'd1;
    localparam logic [2:0] C_NO_IN    = 3'd2;
    localparam logic [2:0] C_LE_TARE  = 3'd3;
    localparam logic [2:0] C_CNT_NZ   = 3'd4;
    localparam logic [2:0] C_NO_MATCH = 3'd5;
    localparam logic [2:0] C_OUT_FREE = 3'd6;

    // program steps
    localparam logic [STEP_W-1:0] S_LOAD  = 3'd0;
    localparam logic [STEP_W-1:0] S_PREP  = 3'd1;
    localparam logic [STEP_W-1:0] S_DIV   = 3'd2;
    localparam logic [STEP_W-1:0] S_WRITE = 3'd3;
    localparam logic [STEP_W-1:0] S_RANK  = 3'd4;
    localparam logic [STEP_W-1:0] S_EMIT  = 3'd5;
    localparam logic [STEP_W-1:0] S_WAIT  = 3'd6;
    localparam logic [STEP_W-1:0] S_BELOW = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic no_in;
        logic le_tare;
        logic cnt_nz;
        logic no_match;
        logic out_free;
    } t_cond;

    // control store: taken jump goes to target, otherwise to the next step
    function automatic t_ctrl ucode_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            S_LOAD:  w = '{op: OP_LOAD,  cond: C_NO_IN,    target: S_LOAD};
            S_PREP:  w = '{op: OP_PREP,  cond: C_LE_TARE,  target: S_BELOW};
            S_DIV:   w = '{op: OP_DIV,   cond: C_CNT_NZ,   target: S_DIV};
            S_WRITE: w = '{op: OP_WRITE, cond: C_NEXT,     target: S_RANK};
            S_RANK:  w = '{op: OP_RANK,  cond: C_NO_MATCH, target: S_RANK};
            S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE, target: S_LOAD};
            S_WAIT:  w = '{op: OP_NOP,   cond: C_JUMP,     target: S_EMIT};
            S_BELOW: w = '{op: OP_BELOW, cond: C_JUMP,     target: S_EMIT};
            default: w = '{op: OP_NOP,   cond: C_JUMP,     target: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/lctsm_ucode.sv @@
// ----------------------------------------------------------------------------
// lctsm_ucode
// Step counter and control store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module lctsm_ucode
    import lctsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_take;

    assign w_ctrl = ucode_rom(r_step);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.cond)
            C_NEXT:     w_take = 1'b0;
            C_JUMP:     w_take = 1'b1;
            C_NO_IN:    w_take = i_cond.no_in;
            C_LE_TARE:  w_take = i_cond.le_tare;
            C_CNT_NZ:   w_take = i_cond.cnt_nz;
            C_NO_MATCH: w_take = i_cond.no_match;
            C_OUT_FREE: w_take = i_cond.out_free;
            default:    w_take = 1'b1;
        endcase
        n_step = w_take ? w_ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ hw/rtl/lctsm_div.sv @@
// ----------------------------------------------------------------------------
// lctsm_div
// Tare subtract and restoring divider, one quotient bit per cycle, with
// saturation detected up front.
// ----------------------------------------------------------------------------
module lctsm_div
    import lctsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_op,
    input  logic [CODE_W-1:0] i_code,
    input  logic [CODE_W-1:0] i_tare,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_cnt_nz,
    output logic [CODE_W-1:0] o_quotient
);

    logic [CODE_W-1:0] w_diff;
    logic              w_sat;
    logic [DIV_W:0]    w_trial;
    logic              w_ge;
    logic [DIV_W:0]    w_sub;

    logic [DIV_W-1:0]  r_rem;
    logic [CODE_W-1:0] r_dvd;
    logic [CODE_W-1:0] r_quo;
    logic              r_sat;
    logic [DCNT_W-1:0] r_cnt;

    assign w_diff = i_code - i_tare;
    // quotient reaches 2^24 exactly when diff / 4096 >= divisor (zero divisor too)
    assign w_sat  = {{(DIV_W-(CODE_W-FRAC_W)){1'b0}}, w_diff[CODE_W-1:FRAC_W]} >= i_divisor;

    assign w_trial = {r_rem, r_dvd[CODE_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_sub   = w_trial - {1'b0, i_divisor};

    assign o_cnt_nz   = r_cnt != '0;
    assign o_quotient = r_sat ? {CODE_W{1'b1}} : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_op == OP_PREP) begin
            r_cnt <= DIV_STEPS_M1;
        end else if (i_op == OP_DIV && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_PREP) begin
            r_sat <= w_sat;
            r_rem <= {{(DIV_W-(CODE_W-FRAC_W)){1'b0}}, w_diff[CODE_W-1:FRAC_W]};
            r_dvd <= {w_diff[FRAC_W-1:0], {(CODE_W-FRAC_W){1'b0}}};
            r_quo <= '0;
        end else if (i_op == OP_DIV) begin
            r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_dvd <= {r_dvd[CODE_W-2:0], 1'b0};
            r_quo <= {r_quo[CODE_W-2:0], w_ge};
        end
    end

endmodule

@@ hw/rtl/lctsm_win.sv @@
// ----------------------------------------------------------------------------
// lctsm_win
// Ring of the last WINDOW weights and the median search: one candidate per
// cycle is ranked against every entry at once.
// ----------------------------------------------------------------------------
module lctsm_win
    import lctsm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_op,
    input  logic [CODE_W-1:0] i_wdata,
    output logic              o_match,
    output logic [CODE_W-1:0] o_median
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic [CODE_W-1:0] r_win [WINDOW];
    logic [IDX_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  r_cand;
    logic [CODE_W-1:0] w_val;
    logic [CNT_W-1:0]  w_rank;

    assign w_val = r_win[r_cand];

    // stable rank: smaller entries, plus equal entries at a lower index
    always_comb begin
        w_rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if (r_win[j] < w_val || (r_win[j] == w_val && IDX_W'(j) < r_cand)) begin
                w_rank = w_rank + 1'b1;
            end
        end
    end

    assign o_match  = w_rank == MID_RANK;
    assign o_median = w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WINDOW; j++) begin
                r_win[j] <= '0;
            end
            r_ptr  <= '0;
            r_cand <= '0;
        end else begin
            case (i_op)
                OP_WRITE: begin
                    r_win[r_ptr] <= i_wdata;
                    r_ptr        <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
                    r_cand       <= '0;
                end
                OP_RANK: begin
                    r_cand <= r_cand + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/load_cell_tare_scale_median.sv @@
// ----------------------------------------------------------------------------
// load_cell_tare_scale_median
// Tare subtract, fixed-point scale and sliding-window median of load-cell
// codes, run by a small control program.
//
//   channel   dir  fields (lsb first)           transfer when
//   s_axis    in   tdata: sample_code[23:0]     i_s_axis_tvalid & o_s_axis_tready
//   m_axis    out  tdata: weight[23:0]          o_m_axis_tvalid & i_m_axis_tready
//                  tuser: below_tare
//   cfg       in   addr: register index         i_cfg_valid & o_cfg_ready
//                  data: 0 tare_offset[23:0], 1 scale_divisor[15:0]
//
// One item at a time: above tare a sample runs prep, the bit-serial divider, the
// window write and the median ranking loop; at or below tare it goes from prep to
// the below step. The result sits in an output register, so the next sample is
// taken while it waits; a stalled result holds the program in its emit/wait steps.
// Reset is synchronous, active low, and clears the window at once.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_median
    import lctsm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [CODE_W-1:0] i_s_axis_tdata,   // sample_code[23:0]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [CODE_W-1:0] o_m_axis_tdata,   // weight[23:0]
    output logic              o_m_axis_tuser,   // below_tare
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CODE_W-1:0] i_cfg_data
);

    t_ctrl             w_ctrl;
    t_cond             w_cond;
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_emit;
    logic              w_cnt_nz;
    logic [CODE_W-1:0] w_quotient;
    logic              w_match;
    logic [CODE_W-1:0] w_median;

    logic [CODE_W-1:0] r_tare;
    logic [DIV_W-1:0]  r_scale;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] r_res_weight;
    logic              r_res_below;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_weight;
    logic              r_out_below;

    // nothing is taken while reset is held
    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = i_rst_n && w_ctrl.op == OP_LOAD;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_emit          = w_ctrl.op == OP_EMIT && w_out_free;

    assign w_cond = '{no_in:    !i_s_axis_tvalid,
                      le_tare:  r_code <= r_tare,
                      cnt_nz:   w_cnt_nz,
                      no_match: !w_match,
                      out_free: w_out_free};

    lctsm_ucode u_ucode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ctrl  (w_ctrl)
    );

    lctsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_ctrl.op),
        .i_code     (r_code),
        .i_tare     (r_tare),
        .i_divisor  (r_scale),
        .o_cnt_nz   (w_cnt_nz),
        .o_quotient (w_quotient)
    );

    lctsm_win #(
        .WINDOW (WINDOW)
    ) u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_ctrl.op),
        .i_wdata  (w_quotient),
        .o_match  (w_match),
        .o_median (w_median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare  <= '0;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_TARE:  r_tare  <= i_cfg_data;
                REG_SCALE: r_scale <= i_cfg_data[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_code <= i_s_axis_tdata;
        end
        if (w_ctrl.op == OP_BELOW) begin
            r_res_weight <= '0;
            r_res_below  <= 1'b1;
        end else if (w_ctrl.op == OP_RANK && w_match) begin
            r_res_weight <= w_median;
            r_res_below  <= 1'b0;
        end
        if (w_emit) begin
            r_out_weight <= r_res_weight;
            r_out_below  <= r_res_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_weight;
    assign o_m_axis_tuser  = r_out_below;

`ifndef ASSERT_OFF
    // an accepted sample is compared against tare in the very next cycle
    a_load_then_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> w_ctrl.op == OP_PREP)
        else $error("sample transfer not followed by prep step");

    // the window is only written once the divider has run down
    a_write_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.op == OP_WRITE |-> $past(w_ctrl.op) == OP_DIV && $past(!w_cnt_nz))
        else $error("window write before divide finished");

    // a below-tare result always carries zero weight
    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("below-tare result with nonzero weight");

    // output register never overwritten while a result is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !(r_out_valid && !i_m_axis_tready))
        else $error("result emitted over a stalled one");
`endif

endmodule
